>>> design/mfmd_pkg.sv
// shared types and constants for the multi-turn motor feedback decoder
package mfmd_pkg;

  localparam int MAX_MOTORS = 8;
  localparam int MOTOR_W    = $clog2(MAX_MOTORS);

  localparam logic [10:0] ID_FIRST = 11'h201;
  localparam logic [10:0] ID_LAST  = 11'h208;
  localparam logic [10:0] ID_BASE  = 11'h200;

  localparam logic signed [15:0] FOLD_LIMIT = 16'sd4096;

  localparam logic [15:0] PPR_RESET       = 16'd8191;
  localparam logic [3:0]  MOTORS_RESET    = 4'd8;
  localparam logic [3:0]  SMALL_RESET     = 4'd4;
  localparam logic [3:0]  MOTOR_LIMIT     = 4'(MAX_MOTORS);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PULSES_PER_ROUND  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTORS_IN_USE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SMALL_MOTOR_COUNT = 2'd2;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_ZERO  = 1'b1;

  // per-motor stored entry: last reading above running total
  localparam int ENTRY_W = 48;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  zero_motor;
    logic        is_standard_id;
    logic        is_data_frame;
    logic [10:0] frame_id;
    logic [63:0] frame_payload;
  } req_beat_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         motor_index;
    logic signed [15:0] raw_angle;
    logic signed [15:0] motor_speed;
    logic signed [15:0] motor_current;
    logic signed [7:0]  motor_temp;
    logic               has_temperature;
    logic signed [15:0] angle_step;
    logic signed [31:0] position_total;
  } rsp_beat_t;

endpackage

>>> design/mfmd_ram.sv
// generic single-write, single-read ram with registered read data
module mfmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/motor_feedback_multiturn_decoder_core.sv
// top level of the multi-turn motor feedback decoder
//
// Takes one beat per clock, unless stalled: a received bus frame or a zero
// request. Each beat gives one result beat, which passes through the decode
// stage and then the result register. Per-motor last reading and running total
// sit in an 8-entry ram read in the cycle the beat is accepted and written
// back as the beat leaves the decode stage; a write to the entry that the next
// beat reads is forwarded, so back-to-back frames for one motor sustain one
// beat per cycle while the output is not stalled. The zero-pending flags and
// the entry valid bits are flip-flops that reset sets or clears at once, so no
// clearing pass is needed. The request side stalls only while a finished
// result waits on a stalled output and the decode stage is also full.
module motor_feedback_multiturn_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  mfmd_pkg::req_beat_t                 req_beat,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output mfmd_pkg::rsp_beat_t                 rsp_beat,
  input  logic                                cfg_wen,
  input  logic [mfmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mfmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mfmd_pkg::*;

  // configuration
  logic [15:0] pulses_per_round;
  logic [3:0]  motors_in_use;
  logic [3:0]  small_motor_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_round  <= PPR_RESET;
      motors_in_use     <= MOTORS_RESET;
      small_motor_count <= SMALL_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PULSES_PER_ROUND:  pulses_per_round  <= cfg_data[15:0];
        REG_MOTORS_IN_USE:     motors_in_use     <= cfg_data[3:0];
        REG_SMALL_MOTOR_COUNT: small_motor_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // decode at acceptance
  logic               accept;
  logic [3:0]         lim;
  logic [3:0]         frame_n;
  logic               id_ok;
  logic               s0_ok;
  logic [MOTOR_W-1:0] s0_motor;

  assign accept = req_valid && !req_stall;

  always_comb begin
    lim     = (motors_in_use > MOTOR_LIMIT) ? MOTOR_LIMIT : motors_in_use;
    frame_n = 4'(req_beat.frame_id - ID_BASE);
    id_ok   = (req_beat.frame_id >= ID_FIRST) && (req_beat.frame_id <= ID_LAST);
    if (req_beat.req_type == REQ_ZERO) begin
      s0_motor = req_beat.zero_motor;
      s0_ok    = {1'b0, req_beat.zero_motor} < lim;
    end else begin
      s0_motor = MOTOR_W'(frame_n - 4'd1);
      s0_ok    = req_beat.is_standard_id && req_beat.is_data_frame && id_ok &&
                 (frame_n <= lim);
    end
  end

  // state ram
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [MOTOR_W-1:0] ram_waddr;

  mfmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MOTORS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (s0_motor),
    .rdata (ram_rdata)
  );

  logic [MAX_MOTORS-1:0] entry_valid;
  logic [MAX_MOTORS-1:0] zero_pending;

  // stage 1 registers
  logic               s1_valid;
  logic               s1_ok;
  logic               s1_zero;
  logic [MOTOR_W-1:0] s1_motor;
  logic [15:0]        s1_angle;
  logic [15:0]        s1_speed;
  logic [15:0]        s1_current;
  logic [7:0]         s1_temp;
  logic               s1_has_temp;
  logic               s1_fwd;
  logic [ENTRY_W-1:0] s1_fwd_data;
  logic               s1_prev_valid;
  logic               s1_move;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok         <= s0_ok;
      s1_zero       <= req_beat.req_type == REQ_ZERO;
      s1_motor      <= s0_motor;
      s1_angle      <= req_beat.frame_payload[63:48];
      s1_speed      <= req_beat.frame_payload[47:32];
      s1_current    <= req_beat.frame_payload[31:16];
      s1_temp       <= req_beat.frame_payload[15:8];
      s1_has_temp   <= frame_n > small_motor_count;
      // write-back landing on the entry being read this edge
      s1_fwd        <= ram_we && (ram_waddr == s0_motor);
      s1_fwd_data   <= ram_wdata;
      s1_prev_valid <= entry_valid[s0_motor];
    end
  end

  // stage 1 arithmetic
  logic [ENTRY_W-1:0] old_entry;
  logic [15:0]        old_last;
  logic [31:0]        old_total;
  logic [15:0]        gap;
  logic [15:0]        step;
  logic [31:0]        total_new;
  rsp_beat_t          s1_rsp;

  always_comb begin
    if (s1_fwd) begin
      old_entry = s1_fwd_data;
    end else if (s1_prev_valid) begin
      old_entry = ram_rdata;
    end else begin
      old_entry = '0;
    end
    old_last  = old_entry[47:32];
    old_total = old_entry[31:0];
    gap       = s1_angle - old_last;
    if (($signed(gap) > FOLD_LIMIT) || ($signed(gap) < -FOLD_LIMIT)) begin
      step = gap[15] ? (gap + pulses_per_round) : (gap - pulses_per_round);
    end else begin
      step = gap;
    end
    total_new = zero_pending[s1_motor] ? 32'd0 : (old_total + {{16{step[15]}}, step});

    s1_rsp = '0;
    if (s1_ok) begin
      s1_rsp.accepted    = 1'b1;
      s1_rsp.motor_index = s1_motor;
      if (s1_zero) begin
        s1_rsp.position_total = old_total;
      end else begin
        s1_rsp.raw_angle       = s1_angle;
        s1_rsp.motor_speed     = s1_speed;
        s1_rsp.motor_current   = s1_current;
        s1_rsp.motor_temp      = s1_has_temp ? s1_temp : 8'd0;
        s1_rsp.has_temperature = s1_has_temp;
        s1_rsp.angle_step      = step;
        s1_rsp.position_total  = total_new;
      end
    end
  end

  assign ram_we    = s1_move && s1_ok && !s1_zero;
  assign ram_waddr = s1_motor;
  assign ram_wdata = {s1_angle, total_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      zero_pending <= '1;
    end else if (s1_move && s1_ok) begin
      if (s1_zero) begin
        zero_pending[s1_motor] <= 1'b1;
      end else begin
        zero_pending[s1_motor] <= 1'b0;
        entry_valid[s1_motor]  <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp_beat <= s1_rsp;
    end
  end

endmodule

>>> dv/feedback_decode_checker.sv
// checker for the motor feedback decoder: tracks config, predicts each result beat and compares
module feedback_decode_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  mfmd_pkg::req_beat_t              req_beat,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  mfmd_pkg::rsp_beat_t              rsp_beat,
  input  logic                             cfg_wen,
  input  logic [mfmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mfmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               outstanding,
  output int                               results_seen,
  output int                               acted_seen
);
  import mfmd_pkg::*;

  logic [15:0] ppr;
  logic [3:0]  motors_cfg;
  logic [3:0]  small_cfg;

  logic [15:0] last_angle [MAX_MOTORS];
  logic [31:0] run_total  [MAX_MOTORS];
  logic        zero_armed [MAX_MOTORS];

  rsp_beat_t expected_fb [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // decode one request beat and advance the per-motor unwrap state
  function automatic rsp_beat_t decode_feedback(input req_beat_t b);
    rsp_beat_t          r;
    int unsigned        lim;
    int unsigned        n;
    logic [2:0]         m;
    logic [15:0]        angle;
    logic signed [15:0] step;
    int                 gap;
    logic               warm;
    r = '0;
    lim = (motors_cfg > MOTOR_LIMIT) ? MAX_MOTORS : motors_cfg;
    if (b.req_type == REQ_ZERO) begin
      if (b.zero_motor < lim) begin
        zero_armed[b.zero_motor] = 1'b1;
        r.accepted = 1'b1;
        r.motor_index = b.zero_motor;
        r.position_total = run_total[b.zero_motor];
      end
      return r;
    end
    if (!b.is_standard_id || !b.is_data_frame || b.frame_id < ID_FIRST ||
        b.frame_id > ID_LAST)
      return r;
    n = b.frame_id - ID_BASE;
    if (n > lim)
      return r;
    m = 3'(n - 1);
    angle = b.frame_payload[63:48];
    step = angle - last_angle[m];
    gap = step;
    // jump past the fold threshold is taken as a wrap through one revolution
    if (gap > int'(FOLD_LIMIT) || gap < -int'(FOLD_LIMIT)) begin
      gap = (gap > 0) ? gap - int'(ppr) : gap + int'(ppr);
      step = 16'(gap);
    end
    last_angle[m] = angle;
    run_total[m] = run_total[m] + {{16{step[15]}}, step};
    if (zero_armed[m]) begin
      run_total[m] = '0;
      zero_armed[m] = 1'b0;
    end
    warm = n > small_cfg;
    r.accepted = 1'b1;
    r.motor_index = m;
    r.raw_angle = angle;
    r.motor_speed = b.frame_payload[47:32];
    r.motor_current = b.frame_payload[31:16];
    r.motor_temp = warm ? b.frame_payload[15:8] : 8'h00;
    r.has_temperature = warm;
    r.angle_step = step;
    r.position_total = run_total[m];
    return r;
  endfunction

  task automatic check_result(input rsp_beat_t got, input rsp_beat_t want);
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("accepted got %0d, expected %0d", got.accepted, want.accepted));
    if (got.motor_index !== want.motor_index)
      report_mismatch($sformatf("motor_index got %0d, expected %0d",
                                got.motor_index, want.motor_index));
    if (got.raw_angle !== want.raw_angle)
      report_mismatch($sformatf("raw_angle got %0d, expected %0d",
                                got.raw_angle, want.raw_angle));
    if (got.motor_speed !== want.motor_speed)
      report_mismatch($sformatf("motor_speed got %0d, expected %0d",
                                got.motor_speed, want.motor_speed));
    if (got.motor_current !== want.motor_current)
      report_mismatch($sformatf("motor_current got %0d, expected %0d",
                                got.motor_current, want.motor_current));
    if (got.motor_temp !== want.motor_temp)
      report_mismatch($sformatf("motor_temp got %0d, expected %0d",
                                got.motor_temp, want.motor_temp));
    if (got.has_temperature !== want.has_temperature)
      report_mismatch($sformatf("has_temperature got %0d, expected %0d",
                                got.has_temperature, want.has_temperature));
    if (got.angle_step !== want.angle_step)
      report_mismatch($sformatf("angle_step got %0d, expected %0d",
                                got.angle_step, want.angle_step));
    if (got.position_total !== want.position_total)
      report_mismatch($sformatf("position_total got %0d, expected %0d",
                                got.position_total, want.position_total));
  endtask

  always @(posedge clk) begin : watch
    rsp_beat_t want;
    if (rst) begin
      ppr = PPR_RESET;
      motors_cfg = MOTORS_RESET;
      small_cfg = SMALL_RESET;
      for (int i = 0; i < MAX_MOTORS; i++) begin
        last_angle[i] = '0;
        run_total[i] = '0;
        zero_armed[i] = 1'b1;
      end
      expected_fb.delete();
      errors = 0;
      results_seen = 0;
      acted_seen = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_PULSES_PER_ROUND:  ppr = cfg_data;
          REG_MOTORS_IN_USE:     motors_cfg = cfg_data[3:0];
          REG_SMALL_MOTOR_COUNT: small_cfg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_fb.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, motor %0d",
                                    rsp_beat.motor_index));
        end else begin
          want = expected_fb.pop_front();
          if (want.accepted)
            acted_seen++;
          check_result(rsp_beat, want);
        end
      end
      if (req_valid && !req_stall)
        expected_fb.push_back(decode_feedback(req_beat));
    end
    outstanding = expected_fb.size();
  end

endmodule

>>> dv/motor_feedback_multiturn_decoder_core_test.sv
// stimulus, reset and verdict for the motor feedback decoder testbench
module motor_feedback_multiturn_decoder_core_test;
  import mfmd_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 300;
  localparam int SETTING_EVERY = 100;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  req_beat_t              req_beat;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_beat_t              rsp_beat;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int errors;
  int outstanding;
  int results_seen;
  int acted_seen;

  logic        req_took = 1'b0;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles = 0;
  int          settings_applied = 0;
  logic [3:0]  motors_now;
  logic [15:0] sent_angle [MAX_MOTORS];

  motor_feedback_multiturn_decoder_core u_top (.*);
  feedback_decode_checker u_check (.*);

  always #(CLK_HALF) clk = ~clk;

  // handshake seen at the last rising edge, read back at the falling edge
  always @(posedge clk) req_took <= req_valid && !req_stall;

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wen) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("motor_feedback_multiturn_decoder_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_beat_t frame_beat(input logic [10:0] id, input logic [63:0] payload,
                                           input logic std_id = 1'b1,
                                           input logic data_fr = 1'b1);
    req_beat_t b;
    b.req_type = REQ_FRAME;
    b.zero_motor = 3'($urandom_range(7));
    b.is_standard_id = std_id;
    b.is_data_frame = data_fr;
    b.frame_id = id;
    b.frame_payload = payload;
    return b;
  endfunction

  // zero request; the frame fields ride along as noise
  function automatic req_beat_t zero_beat(input logic [2:0] m);
    req_beat_t b;
    b.req_type = REQ_ZERO;
    b.zero_motor = m;
    b.is_standard_id = 1'($urandom);
    b.is_data_frame = 1'($urandom);
    b.frame_id = 11'($urandom);
    b.frame_payload = {$urandom, $urandom};
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic push_req(input req_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_beat <= b;
    do @(negedge clk); while (!req_took);
  endtask

  task automatic wait_results_in();
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] ppr_val, input logic [3:0] motors_val,
                                input logic [3:0] small_val);
    wait_results_in();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= REG_PULSES_PER_ROUND;
    cfg_data <= ppr_val;
    @(negedge clk);
    cfg_index <= REG_MOTORS_IN_USE;
    cfg_data <= CFG_DATA_W'(motors_val);
    @(negedge clk);
    cfg_index <= REG_SMALL_MOTOR_COUNT;
    cfg_data <= CFG_DATA_W'(small_val);
    @(negedge clk);
    cfg_wen <= 1'b0;
    motors_now = motors_val;
    settings_applied++;
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
    logic [15:0] ppr_pick;
    logic [3:0]  motors_pick;
    logic [3:0]  small_pick;
    logic [15:0] angle;
    logic [10:0] id;
    logic [2:0]  m;
    int unsigned pick;
    int          delta;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      if (i % SETTING_EVERY == 0) begin
        case ($urandom_range(3))
          0:       ppr_pick = 16'd1;
          1:       ppr_pick = 16'hFFFF;
          2:       ppr_pick = PPR_RESET;
          default: ppr_pick = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(2))
          0:       motors_pick = 4'd1;
          1:       motors_pick = MOTOR_LIMIT;
          default: motors_pick = 4'($urandom_range(1, MAX_MOTORS));
        endcase
        case ($urandom_range(2))
          0:       small_pick = 4'd0;
          1:       small_pick = MOTOR_LIMIT;
          default: small_pick = 4'($urandom_range(0, MAX_MOTORS));
        endcase
        apply_settings(ppr_pick, motors_pick, small_pick);
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed feedback frame, mostly small moves with some wrap jumps
        m = 3'($urandom_range(0, motors_now - 1));
        case ($urandom_range(3))
          0, 1: delta = $urandom_range(0, 400) - 200;
          2:    delta = int'(FOLD_LIMIT) - 1 + $urandom_range(0, 3000);
          default: delta = int'($urandom);
        endcase
        if ($urandom_range(1))
          delta = -delta;
        angle = 16'(int'(sent_angle[m]) + delta);
        sent_angle[m] = angle;
        push_req(frame_beat(ID_BASE + 11'(m) + 11'd1,
                            {angle, 32'($urandom), 16'($urandom)}));
      end else if (pick < 82) begin
        push_req(zero_beat(3'($urandom_range(7))));
      end else begin
        id = $urandom_range(1) ? 11'($urandom)
                               : 11'($urandom_range(ID_BASE - 2, ID_LAST + 2));
        push_req(frame_beat(id, {$urandom, $urandom}, 1'($urandom), 1'($urandom)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_beat = '0;
    cfg_wen = 1'b0;
    cfg_index = REG_PULSES_PER_ROUND;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    motors_now = MOTORS_RESET;
    for (int i = 0; i < MAX_MOTORS; i++)
      sent_angle[i] = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // first frame per motor clears, then folds around the threshold both ways
    push_req(frame_beat(ID_FIRST, {16'h0000, 16'h7FFF, 16'h8000, 8'h7F, 8'h00}));
    push_req(frame_beat(ID_FIRST, {16'd4096, 16'h8000, 16'h7FFF, 8'h80, 8'hFF}));
    push_req(frame_beat(ID_FIRST, {16'd8193, 48'h1234_5678_9ABC}));
    push_req(frame_beat(ID_FIRST, {16'd4096, 48'hFEDC_BA98_7654}));
    push_req(frame_beat(ID_FIRST, {16'd0, 48'h0}));
    push_req(frame_beat(ID_FIRST, {16'h8000, 48'h0001_0002_0300}));
    push_req(frame_beat(ID_FIRST, {16'hFFFF, 48'h0123_4567_89AB}));
    push_req(frame_beat(ID_LAST, 64'hFFFF_FFFF_FFFF_FFFF));
    push_req(frame_beat(ID_LAST, 64'h0));
    // identifiers just outside the window, extremes, wrong frame kinds
    push_req(frame_beat(ID_BASE, 64'hFFFF_FFFF_FFFF_FFFF));
    push_req(frame_beat(ID_LAST + 11'd1, 64'h5555_AAAA_5555_AAAA));
    push_req(frame_beat(11'h7FF, 64'hAAAA_5555_AAAA_5555));
    push_req(frame_beat(11'h000, 64'h0));
    push_req(frame_beat(ID_BASE + 11'd5, 64'h1000_0000_0000_0000, 1'b0, 1'b1));
    push_req(frame_beat(ID_BASE + 11'd5, 64'h1000_0000_0000_0000, 1'b1, 1'b0));
    // zero request reports the old total, next frame clears it
    push_req(zero_beat(3'd0));
    push_req(frame_beat(ID_FIRST, {16'h0100, 48'h0}));
    push_req(zero_beat(3'd7));
    push_req(frame_beat(ID_LAST, {16'h7FFF, 48'h0000_0000_C300}));
    // temperature boundary at the small motor count
    push_req(frame_beat(ID_BASE + 11'd5, {16'h0200, 48'h0000_0000_1900}));
    push_req(frame_beat(ID_BASE + 11'd4, {16'h0200, 48'h0000_0000_1900}));

    apply_settings(16'd1, 4'd1, 4'd0);
    push_req(frame_beat(ID_FIRST, {16'h7FFF, 48'h0000_0000_8000}));
    push_req(frame_beat(ID_BASE + 11'd2, {16'h0000, 48'h0}));
    push_req(zero_beat(3'd1));
    push_req(zero_beat(3'd0));

    apply_settings(16'hFFFF, MOTOR_LIMIT, MOTOR_LIMIT);
    push_req(frame_beat(ID_LAST, {16'h8001, 48'h0000_0000_5500}));

    run_phase(PHASE_ITEMS, 20, 49);
    run_phase(PHASE_ITEMS, 49, 20);
    run_phase(PHASE_ITEMS, 0, 0);

    wait_results_in();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d beats under %0d register settings, %0d acted on by the decoder",
             results_seen, settings_applied, acted_seen);
    $display("idle mixes: sender 20%%/receiver 49%%, sender 49%%/receiver 20%%, then none");
    if (errors == 0 && outstanding == 0) begin
      $display("motor_feedback_multiturn_decoder_core_test: done, clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors, outstanding);
      $display("motor_feedback_multiturn_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mfmd_pkg.sv
design/mfmd_ram.sv
design/motor_feedback_multiturn_decoder_core.sv
dv/feedback_decode_checker.sv
dv/motor_feedback_multiturn_decoder_core_test.sv
